// ===== rtl/assert_macros.svh =====
// assertion macros shared by the controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock edge, off while in reset
`define BRHC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define BRHC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BRHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/brhc_pkg.sv =====
// types, codes and fixed field widths of the relay hysteresis controller
package brhc_pkg;

	// fixed field widths
	localparam int ACTION_W   = 2;
	localparam int NOW_W      = 40;
	localparam int VOLT_W     = 15;
	localparam int CURR_W     = 16;
	localparam int POWER_W    = 15;
	localparam int HOLD_W     = 32;
	localparam int ENERGY_W   = 64;
	localparam int VSMOOTH_W  = 23;
	localparam int CSMOOTH_W  = 24;
	localparam int STATUS_W   = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 5;

	// lowest voltage that counts as a valid sample (1.0 V)
	localparam logic [VOLT_W-1:0] VOLT_MIN_RAW = 15'd800;

	// configuration reset values
	localparam logic [VOLT_W-1:0] R1_ON_BELOW_RST  = 15'd9680;
	localparam logic [VOLT_W-1:0] R1_OFF_ABOVE_RST = 15'd10560;
	localparam logic [CURR_W-1:0] R1_OFF_MIN_RST   = 16'd150;
	localparam logic [VOLT_W-1:0] R2_OFF_BELOW_RST = 15'd9680;
	localparam logic [VOLT_W-1:0] R2_ON_ABOVE_RST  = 15'd10560;
	localparam logic [HOLD_W-1:0] R1_HOLD_RST      = 32'd60000;
	localparam logic [HOLD_W-1:0] R2_HOLD_RST      = 32'd10000;
	localparam logic [VOLT_W-1:0] CRIT_BAND_RST    = 15'd160;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_MANUAL = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_APPLIED    = 2'd0,
		ST_READ_ERR   = 2'd1,
		ST_UNDER_VOLT = 2'd2,
		ST_CMD_DONE   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_R1_ON_BELOW  = 3'd0,
		REG_R1_OFF_ABOVE = 3'd1,
		REG_R1_OFF_MIN   = 3'd2,
		REG_R2_OFF_BELOW = 3'd3,
		REG_R2_ON_ABOVE  = 3'd4,
		REG_R1_HOLD      = 3'd5,
		REG_R2_HOLD      = 3'd6,
		REG_CRIT_BAND    = 3'd7
	} cfg_reg_t;

	// one input item
	typedef struct packed {
		logic [ACTION_W-1:0]      action;
		logic [NOW_W-1:0]         now_ms;
		logic [VOLT_W-1:0]        voltage_raw;
		logic signed [CURR_W-1:0] current_raw;
		logic [POWER_W-1:0]       power_raw;
		logic                     read_ok;
		logic                     relay_select;
		logic                     relay_value;
	} item_t;

	// one result item
	typedef struct packed {
		logic                        relay1_out;
		logic                        relay2_out;
		logic [VSMOOTH_W-1:0]        volt_smoothed;
		logic signed [CSMOOTH_W-1:0] curr_smoothed;
		logic [VOLT_W-1:0]           volt_peak;
		logic [VOLT_W-1:0]           curr_peak;
		logic [POWER_W-1:0]          power_peak;
		logic [ENERGY_W-1:0]         energy_sum;
		logic                        fast_sampling;
		logic [NOW_W-1:0]            relay1_on_total;
		logic [NOW_W-1:0]            relay2_on_total;
		logic [STATUS_W-1:0]         status;
	} result_t;

	// per-relay control for one transfer
	typedef struct packed {
		logic sample;   // valid sample: run the hold timer
		logic req_on;   // thresholds ask for on
		logic req_off;  // thresholds ask for off
		logic manual;   // manual set of this relay
		logic value;    // manual set value
		logic clear;    // statistics reset
	} relay_ctl_t;

endpackage

// ===== rtl/brhc_if.sv =====
// valid/ready channels for input samples and result items
interface brhc_in_if;
	logic                              valid;
	logic                              ready;
	logic [brhc_pkg::ACTION_W-1:0]     action;
	logic [brhc_pkg::NOW_W-1:0]        now_ms;
	logic [brhc_pkg::VOLT_W-1:0]       voltage_raw;
	logic signed [brhc_pkg::CURR_W-1:0] current_raw;
	logic [brhc_pkg::POWER_W-1:0]      power_raw;
	logic                              read_ok;
	logic                              relay_select;
	logic                              relay_value;

	modport source (
		output valid, action, now_ms, voltage_raw, current_raw, power_raw,
		       read_ok, relay_select, relay_value,
		input  ready
	);
	modport sink (
		input  valid, action, now_ms, voltage_raw, current_raw, power_raw,
		       read_ok, relay_select, relay_value,
		output ready
	);
endinterface

interface brhc_out_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  relay1_out;
	logic                                  relay2_out;
	logic [brhc_pkg::VSMOOTH_W-1:0]        volt_smoothed;
	logic signed [brhc_pkg::CSMOOTH_W-1:0] curr_smoothed;
	logic [brhc_pkg::VOLT_W-1:0]           volt_peak;
	logic [brhc_pkg::VOLT_W-1:0]           curr_peak;
	logic [brhc_pkg::POWER_W-1:0]          power_peak;
	logic [brhc_pkg::ENERGY_W-1:0]         energy_sum;
	logic                                  fast_sampling;
	logic [brhc_pkg::NOW_W-1:0]            relay1_on_total;
	logic [brhc_pkg::NOW_W-1:0]            relay2_on_total;
	logic [brhc_pkg::STATUS_W-1:0]         status;

	modport source (
		output valid, relay1_out, relay2_out, volt_smoothed, curr_smoothed, volt_peak,
		       curr_peak, power_peak, energy_sum, fast_sampling, relay1_on_total,
		       relay2_on_total, status,
		input  ready
	);
	modport sink (
		input  valid, relay1_out, relay2_out, volt_smoothed, curr_smoothed, volt_peak,
		       curr_peak, power_peak, energy_sum, fast_sampling, relay1_on_total,
		       relay2_on_total, status,
		output ready
	);
endinterface

// ===== rtl/brhc_div5.sv =====
// unsigned floor division by five through a reciprocal multiply
module brhc_div5 #(
	parameter int W = 26
) (
	input  logic [W-1:0] num,
	output logic [W-1:0] quot
);

	// exact for every num below 2^W: m = ceil(2^(W+3) / 5), shift by W+3
	localparam logic [W+3:0] TWO_POW = (W+4)'(1) << (W + 3);
	localparam logic [W:0]   RECIP   = (W+1)'(TWO_POW / 5 + 1);

	logic [2*W:0] prod;

	assign prod = (2*W+1)'(num) * (2*W+1)'(RECIP);
	assign quot = W'(prod >> (W + 3));

endmodule

// ===== rtl/brhc_relay.sv =====
// one relay: hold timer, manual set and on-time accounting
module brhc_relay #(
	parameter int TIME_BITS = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  brhc_pkg::relay_ctl_t          ctl,
	input  logic [TIME_BITS-1:0]          now,
	input  logic [brhc_pkg::HOLD_W-1:0]   hold,
	output logic                          on_next,
	output logic [TIME_BITS-1:0]          total_next
);

	logic                 on_q, pend_q;
	logic [TIME_BITS-1:0] start_q, accum_q, since_q;
	logic                 pend_n;
	logic [TIME_BITS-1:0] start_n, accum_n, since_n;

	logic                 desired;
	logic [TIME_BITS-1:0] start_eff;
	logic                 held;
	logic [TIME_BITS:0]   acc_sum;
	logic [TIME_BITS-1:0] acc_sat;
	logic                 sw_en, sw_val;
	logic [TIME_BITS-1:0] sess_n;
	logic [TIME_BITS:0]   tot_sum;

	// request resolves to the current state when no threshold is crossed
	assign desired   = ctl.req_on | (on_q & ~ctl.req_off);
	assign start_eff = pend_q ? start_q : now;
	assign held      = (now - start_eff) >= TIME_BITS'(hold);

	// closing the running session, saturating
	assign acc_sum = {1'b0, accum_q} + {1'b0, now - since_q};
	assign acc_sat = acc_sum[TIME_BITS] ? '1 : acc_sum[TIME_BITS-1:0];

	// switch decision from the hold timer or a manual set
	always_comb begin
		pend_n  = pend_q;
		start_n = start_q;
		sw_en   = 1'b0;
		sw_val  = on_q;
		if (ctl.sample) begin
			if (desired != on_q) begin
				pend_n  = 1'b1;
				start_n = start_eff;
				if (held) begin
					sw_en  = 1'b1;
					sw_val = desired;
					pend_n = 1'b0;
				end
			end else begin
				pend_n = 1'b0;
			end
		end
		if (ctl.manual) begin
			sw_en  = 1'b1;
			sw_val = ctl.value;
		end
	end

	// state and on-time after the transfer
	always_comb begin
		on_next = on_q;
		accum_n = accum_q;
		since_n = since_q;
		if (sw_en) begin
			if (sw_val && !on_q) begin
				since_n = now;
			end else if (!sw_val && on_q) begin
				accum_n = acc_sat;
			end
			on_next = sw_val;
		end
		if (ctl.clear) begin
			accum_n = '0;
			if (on_q) begin
				since_n = now;
			end
		end
	end

	// on-time including the running session
	assign sess_n     = now - since_n;
	assign tot_sum    = {1'b0, accum_n} + {1'b0, sess_n};
	assign total_next = !on_next ? accum_n :
	                    (tot_sum[TIME_BITS] ? '1 : tot_sum[TIME_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q    <= 1'b0;
			pend_q  <= 1'b0;
			start_q <= '0;
			accum_q <= '0;
			since_q <= '0;
		end else if (ctl.sample || ctl.manual || ctl.clear) begin
			on_q    <= on_next;
			pend_q  <= pend_n;
			start_q <= start_n;
			accum_q <= accum_n;
			since_q <= since_n;
		end
	end

endmodule

// ===== rtl/battery_relay_hysteresis_controller.sv =====
// Battery relay hysteresis controller: filter, relay hysteresis, statistics.
// An item passes the input register, then the result register; their data are not reset.
// Throughput: one item per cycle while the result is not stalled; the state update runs
// through the divide-by-five reciprocal multiply to the threshold compares and hold timers.
// Reset (arst_n low, asynchronous) clears other state and loads the configuration defaults.
`include "assert_macros.svh"

module battery_relay_hysteresis_controller #(
	parameter int TIME_BITS        = 40,
	parameter int FILTER_FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [brhc_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [brhc_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [brhc_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	brhc_in_if.sink                           item,
	brhc_out_if.source                        result
);

	localparam int F        = FILTER_FRAC_BITS;
	localparam int VF_W     = brhc_pkg::VOLT_W + F;
	localparam int CF_W     = brhc_pkg::CURR_W + F;
	localparam int DIV_W    = VF_W + 3;
	localparam int CN_W     = CF_W + 3;
	localparam int PROD_W   = brhc_pkg::POWER_W + TIME_BITS;
	localparam int PROD_X_W = brhc_pkg::POWER_W + brhc_pkg::ENERGY_W;

	// configuration registers
	logic [brhc_pkg::VOLT_W-1:0] r1_on_below_q, r1_off_above_q, r2_off_below_q;
	logic [brhc_pkg::VOLT_W-1:0] r2_on_above_q, crit_band_q;
	logic [brhc_pkg::CURR_W-1:0] r1_off_min_q;
	logic [brhc_pkg::HOLD_W-1:0] r1_hold_q, r2_hold_q;
	logic                        cfg_wr;
	logic [2:0]                  cfg_idx;

	// handshake
	logic                  s1_valid_q, out_valid_q;
	brhc_pkg::item_t       item_s1;
	brhc_pkg::result_t     result_q, res_n;
	logic                  out_free, fire;

	// block state
	logic                        primed_q;
	logic [VF_W-1:0]             vf_q;
	logic signed [CF_W-1:0]      cf_q;
	logic [brhc_pkg::VOLT_W-1:0] vmax_q, cmax_q;
	logic [brhc_pkg::POWER_W-1:0] pmax_q;
	logic [brhc_pkg::ENERGY_W-1:0] energy_q;
	logic [TIME_BITS-1:0]        last_t_q;

	// next state and datapath
	logic                        is_sample, valid_sample, is_manual, is_clear;
	logic [TIME_BITS-1:0]        now_t, elapsed;
	logic [PROD_W-1:0]           energy_prod;
	logic [PROD_X_W-1:0]         prod_x;
	logic [brhc_pkg::ENERGY_W:0] energy_sum;
	logic [brhc_pkg::ENERGY_W-1:0] energy_add;
	logic [DIV_W-1:0]            vnum, vquot, cdiv_in, cquot;
	logic signed [CN_W-1:0]      cnum;
	logic                        cneg;
	logic [CF_W-1:0]             cquot_t;
	logic [VF_W-1:0]             vf_n;
	logic signed [CF_W-1:0]      cf_n;
	logic                        primed_n;
	logic [brhc_pkg::VOLT_W-1:0] vmax_n, cmax_n;
	logic [brhc_pkg::POWER_W-1:0] pmax_n;
	logic [brhc_pkg::ENERGY_W-1:0] energy_n;
	logic                        r1_set, r1_rst, r2_set, r2_rst;
	brhc_pkg::relay_ctl_t        r1_ctl, r2_ctl;
	logic                        r1_on_n, r2_on_n;
	logic [TIME_BITS-1:0]        r1_total, r2_total;
	logic [brhc_pkg::VOLT_W-1:0] fast_thr [4];
	logic signed [VF_W:0]        fast_d [4];
	logic [VF_W:0]               fast_mag [4];
	logic                        fast;
	logic [brhc_pkg::STATUS_W-1:0] status_n;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[brhc_pkg::CFG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r1_on_below_q  <= brhc_pkg::R1_ON_BELOW_RST;
			r1_off_above_q <= brhc_pkg::R1_OFF_ABOVE_RST;
			r1_off_min_q   <= brhc_pkg::R1_OFF_MIN_RST;
			r2_off_below_q <= brhc_pkg::R2_OFF_BELOW_RST;
			r2_on_above_q  <= brhc_pkg::R2_ON_ABOVE_RST;
			r1_hold_q      <= brhc_pkg::R1_HOLD_RST;
			r2_hold_q      <= brhc_pkg::R2_HOLD_RST;
			crit_band_q    <= brhc_pkg::CRIT_BAND_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				brhc_pkg::REG_R1_ON_BELOW:  r1_on_below_q  <= pwdata[brhc_pkg::VOLT_W-1:0];
				brhc_pkg::REG_R1_OFF_ABOVE: r1_off_above_q <= pwdata[brhc_pkg::VOLT_W-1:0];
				brhc_pkg::REG_R1_OFF_MIN:   r1_off_min_q   <= pwdata[brhc_pkg::CURR_W-1:0];
				brhc_pkg::REG_R2_OFF_BELOW: r2_off_below_q <= pwdata[brhc_pkg::VOLT_W-1:0];
				brhc_pkg::REG_R2_ON_ABOVE:  r2_on_above_q  <= pwdata[brhc_pkg::VOLT_W-1:0];
				brhc_pkg::REG_R1_HOLD:      r1_hold_q      <= pwdata[brhc_pkg::HOLD_W-1:0];
				brhc_pkg::REG_R2_HOLD:      r2_hold_q      <= pwdata[brhc_pkg::HOLD_W-1:0];
				brhc_pkg::REG_CRIT_BAND:    crit_band_q    <= pwdata[brhc_pkg::VOLT_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (cfg_idx)
			brhc_pkg::REG_R1_ON_BELOW:  prdata = brhc_pkg::CFG_DATA_W'(r1_on_below_q);
			brhc_pkg::REG_R1_OFF_ABOVE: prdata = brhc_pkg::CFG_DATA_W'(r1_off_above_q);
			brhc_pkg::REG_R1_OFF_MIN:   prdata = brhc_pkg::CFG_DATA_W'(r1_off_min_q);
			brhc_pkg::REG_R2_OFF_BELOW: prdata = brhc_pkg::CFG_DATA_W'(r2_off_below_q);
			brhc_pkg::REG_R2_ON_ABOVE:  prdata = brhc_pkg::CFG_DATA_W'(r2_on_above_q);
			brhc_pkg::REG_R1_HOLD:      prdata = brhc_pkg::CFG_DATA_W'(r1_hold_q);
			brhc_pkg::REG_R2_HOLD:      prdata = brhc_pkg::CFG_DATA_W'(r2_hold_q);
			brhc_pkg::REG_CRIT_BAND:    prdata = brhc_pkg::CFG_DATA_W'(crit_band_q);
			default:                    prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	assign out_free   = !out_valid_q || result.ready;
	assign fire       = s1_valid_q && out_free;
	assign item.ready = !s1_valid_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				s1_valid_q <= 1'b1;
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.action       <= item.action;
			item_s1.now_ms       <= item.now_ms;
			item_s1.voltage_raw  <= item.voltage_raw;
			item_s1.current_raw  <= item.current_raw;
			item_s1.power_raw    <= item.power_raw;
			item_s1.read_ok      <= item.read_ok;
			item_s1.relay_select <= item.relay_select;
			item_s1.relay_value  <= item.relay_value;
		end
	end

	// ---------------- item decode ----------------
	assign is_sample    = fire && (item_s1.action == brhc_pkg::ACT_SAMPLE);
	assign valid_sample = is_sample && item_s1.read_ok &&
	                      (item_s1.voltage_raw >= brhc_pkg::VOLT_MIN_RAW);
	assign is_manual    = fire && (item_s1.action == brhc_pkg::ACT_MANUAL);
	assign is_clear     = fire && (item_s1.action == brhc_pkg::ACT_CLEAR);

	always_comb begin
		case (item_s1.action)
			brhc_pkg::ACT_SAMPLE: begin
				if (!item_s1.read_ok) begin
					status_n = brhc_pkg::ST_READ_ERR;
				end else if (item_s1.voltage_raw < brhc_pkg::VOLT_MIN_RAW) begin
					status_n = brhc_pkg::ST_UNDER_VOLT;
				end else begin
					status_n = brhc_pkg::ST_APPLIED;
				end
			end
			default: status_n = brhc_pkg::ST_CMD_DONE;
		endcase
	end

	// ---------------- energy ----------------
	assign now_t       = TIME_BITS'(item_s1.now_ms);
	assign elapsed     = now_t - last_t_q;
	assign energy_prod = PROD_W'(item_s1.power_raw) * PROD_W'(elapsed);
	assign prod_x      = PROD_X_W'(energy_prod);
	assign energy_sum  = {1'b0, energy_q} + {1'b0, prod_x[brhc_pkg::ENERGY_W-1:0]};
	assign energy_add  = (|prod_x[PROD_X_W-1:brhc_pkg::ENERGY_W] ||
	                      energy_sum[brhc_pkg::ENERGY_W]) ? '1 :
	                     energy_sum[brhc_pkg::ENERGY_W-1:0];

	// ---------------- 4:1 filter, rounded ----------------
	assign vnum = (DIV_W'(vf_q) << 2) + (DIV_W'(item_s1.voltage_raw) << F) + DIV_W'(2);
	assign cnum = (CN_W'(cf_q) <<< 2) + (CN_W'($signed(item_s1.current_raw)) <<< F) +
	              CN_W'(2);
	// floor of a negative numerator through the one's complement
	assign cneg    = cnum[CN_W-1];
	assign cdiv_in = cneg ? ~cnum[DIV_W-1:0] : cnum[DIV_W-1:0];
	assign cquot_t = CF_W'(cquot);

	brhc_div5 #(.W(DIV_W)) u_vdiv (.num(vnum),    .quot(vquot));
	brhc_div5 #(.W(DIV_W)) u_cdiv (.num(cdiv_in), .quot(cquot));

	// ---------------- next state ----------------
	always_comb begin
		vf_n     = vf_q;
		cf_n     = cf_q;
		primed_n = primed_q;
		vmax_n   = vmax_q;
		cmax_n   = cmax_q;
		pmax_n   = pmax_q;
		energy_n = energy_q;
		if (valid_sample) begin
			if (item_s1.voltage_raw > vmax_q) begin
				vmax_n = item_s1.voltage_raw;
			end
			if ($signed(item_s1.current_raw) > $signed({1'b0, cmax_q})) begin
				cmax_n = item_s1.current_raw[brhc_pkg::VOLT_W-1:0];
			end
			if (item_s1.power_raw > pmax_q) begin
				pmax_n = item_s1.power_raw;
			end
			energy_n = energy_add;
			if (!primed_q) begin
				vf_n = {item_s1.voltage_raw, {F{1'b0}}};
				cf_n = $signed({item_s1.current_raw, {F{1'b0}}});
			end else begin
				vf_n = VF_W'(vquot);
				cf_n = $signed(cneg ? ~cquot_t : cquot_t);
			end
			primed_n = 1'b1;
		end
		if (is_clear) begin
			vmax_n   = '0;
			cmax_n   = '0;
			pmax_n   = '0;
			energy_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			vf_q     <= '0;
			cf_q     <= '0;
			vmax_q   <= '0;
			cmax_q   <= '0;
			pmax_q   <= '0;
			energy_q <= '0;
			last_t_q <= '0;
		end else if (fire) begin
			primed_q <= primed_n;
			vf_q     <= vf_n;
			cf_q     <= cf_n;
			vmax_q   <= vmax_n;
			cmax_q   <= cmax_n;
			pmax_q   <= pmax_n;
			energy_q <= energy_n;
			if (is_sample) begin
				last_t_q <= now_t;
			end
		end
	end

	// ---------------- relay requests ----------------
	assign r1_set = vf_n <= {r1_on_below_q, {F{1'b0}}};
	assign r1_rst = !r1_set && (vf_n >= {r1_off_above_q, {F{1'b0}}}) &&
	                (cf_n >= $signed({r1_off_min_q, {F{1'b0}}}));
	assign r2_rst = vf_n <= {r2_off_below_q, {F{1'b0}}};
	assign r2_set = !r2_rst && (vf_n >= {r2_on_above_q, {F{1'b0}}});

	always_comb begin
		r1_ctl.sample  = valid_sample;
		r1_ctl.req_on  = r1_set;
		r1_ctl.req_off = r1_rst;
		r1_ctl.manual  = is_manual && !item_s1.relay_select;
		r1_ctl.value   = item_s1.relay_value;
		r1_ctl.clear   = is_clear;
		r2_ctl.sample  = valid_sample;
		r2_ctl.req_on  = r2_set;
		r2_ctl.req_off = r2_rst;
		r2_ctl.manual  = is_manual && item_s1.relay_select;
		r2_ctl.value   = item_s1.relay_value;
		r2_ctl.clear   = is_clear;
	end

	brhc_relay #(.TIME_BITS(TIME_BITS)) u_relay1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (r1_ctl),
		.now        (now_t),
		.hold       (r1_hold_q),
		.on_next    (r1_on_n),
		.total_next (r1_total)
	);

	brhc_relay #(.TIME_BITS(TIME_BITS)) u_relay2 (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (r2_ctl),
		.now        (now_t),
		.hold       (r2_hold_q),
		.on_next    (r2_on_n),
		.total_next (r2_total)
	);

	// ---------------- fast sampling near any threshold ----------------
	always_comb begin
		fast_thr[0] = r1_off_above_q;
		fast_thr[1] = r1_on_below_q;
		fast_thr[2] = r2_on_above_q;
		fast_thr[3] = r2_off_below_q;
		fast = 1'b0;
		for (int i = 0; i < 4; i++) begin
			fast_d[i]   = $signed({1'b0, vf_n}) - $signed({1'b0, fast_thr[i], {F{1'b0}}});
			fast_mag[i] = fast_d[i][VF_W] ? (VF_W+1)'(-fast_d[i]) : (VF_W+1)'(fast_d[i]);
			if (fast_mag[i] < (VF_W+1)'({crit_band_q, {F{1'b0}}})) begin
				fast = primed_n;
			end
		end
	end

	// ---------------- result register ----------------
	always_comb begin
		res_n.relay1_out      = r1_on_n;
		res_n.relay2_out      = r2_on_n;
		res_n.volt_smoothed   = brhc_pkg::VSMOOTH_W'(vf_n);
		res_n.curr_smoothed   = brhc_pkg::CSMOOTH_W'(cf_n);
		res_n.volt_peak       = vmax_n;
		res_n.curr_peak       = cmax_n;
		res_n.power_peak      = pmax_n;
		res_n.energy_sum      = energy_n;
		res_n.fast_sampling   = fast;
		res_n.relay1_on_total = brhc_pkg::NOW_W'(r1_total);
		res_n.relay2_on_total = brhc_pkg::NOW_W'(r2_total);
		res_n.status          = status_n;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= res_n;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.relay1_out      = result_q.relay1_out;
	assign result.relay2_out      = result_q.relay2_out;
	assign result.volt_smoothed   = result_q.volt_smoothed;
	assign result.curr_smoothed   = result_q.curr_smoothed;
	assign result.volt_peak       = result_q.volt_peak;
	assign result.curr_peak       = result_q.curr_peak;
	assign result.power_peak      = result_q.power_peak;
	assign result.energy_sum      = result_q.energy_sum;
	assign result.fast_sampling   = result_q.fast_sampling;
	assign result.relay1_on_total = result_q.relay1_on_total;
	assign result.relay2_on_total = result_q.relay2_on_total;
	assign result.status          = result_q.status;

	// ---------------- assertions ----------------
	`BRHC_ASSERT(a_primed_sticky, clk, arst_n, !$fell(primed_q), "filter lost its primed state")
	`BRHC_ASSERT_NEXT(a_bad_read_keeps_filter, clk, arst_n, is_sample && !item_s1.read_ok, $stable(vf_q) && $stable(cf_q), "read error changed the filter")
	`BRHC_ASSERT_NEXT(a_energy_grows, clk, arst_n, fire && !is_clear, energy_q >= $past(energy_q), "energy sum fell without a statistics reset")
	`BRHC_ASSERT_NEXT(a_idle_holds_state, clk, arst_n, !fire, $stable(vmax_q) && $stable(energy_q) && $stable(last_t_q), "state moved without a transfer")
	`BRHC_ASSERT_IMP(a_clear_zeroes_peaks, clk, arst_n, is_clear, (vmax_n == '0) && (pmax_n == '0) && (energy_n == '0), "statistics reset left a peak or energy")

endmodule
